[src/mst_pkg.sv]
// shared types and codes for the masked sad template matcher
`default_nettype none

package mst_pkg;

    // input item actions
    typedef enum logic [1:0] {
        ACT_LOAD_TEMPLATE = 2'd0,
        ACT_LOAD_SOURCE   = 2'd1,
        ACT_SEARCH        = 2'd2
    } t_action;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_TEMPLATE_WIDTH  = 2'd0,
        REG_TEMPLATE_HEIGHT = 2'd1,
        REG_SOURCE_WIDTH    = 2'd2,
        REG_SOURCE_HEIGHT   = 2'd3
    } t_reg_index;

    // search sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV_LOAD,
        ST_DIV_WAIT
    } t_state;

    // pipeline tag that travels with each pixel read
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_tag;

    // configuration reset values
    localparam logic [6:0] TEMPLATE_WIDTH_RESET  = 7'd16;
    localparam logic [6:0] TEMPLATE_HEIGHT_RESET = 7'd16;
    localparam logic [8:0] SOURCE_WIDTH_RESET    = 9'd256;
    localparam logic [8:0] SOURCE_HEIGHT_RESET   = 9'd256;

    // width of one rgb pixel, of the template word with its keep bit and of the difference result
    localparam int PIXEL_W = 24;
    localparam int TPL_W   = 25;
    localparam int DIFF_W  = 10;

endpackage

`default_nettype wire

[src/mst_stores.sv]
// source image memory and template memory with its two read ports
`default_nettype none

module mst_stores #(
    parameter int SRC_AW = 16,
    parameter int TPL_AW = 12
) (
    input  wire                           i_clk,
    input  wire                           i_src_we,
    input  wire  [SRC_AW-1:0]             i_src_waddr,
    input  wire  [mst_pkg::PIXEL_W-1:0]   i_src_wdata,
    input  wire  [SRC_AW-1:0]             i_src_raddr,
    output logic [mst_pkg::PIXEL_W-1:0]   o_src_rdata,
    input  wire                           i_tpl_we,
    input  wire  [TPL_AW-1:0]             i_tpl_waddr,
    input  wire  [mst_pkg::TPL_W-1:0]     i_tpl_wdata,
    input  wire  [TPL_AW-1:0]             i_tpl_raddr_a,
    input  wire  [TPL_AW-1:0]             i_tpl_raddr_b,
    output logic [mst_pkg::TPL_W-1:0]     o_tpl_rdata_a,
    output logic [mst_pkg::TPL_W-1:0]     o_tpl_rdata_b
);

    logic [mst_pkg::PIXEL_W-1:0] r_src_mem [2**SRC_AW];
    logic [mst_pkg::TPL_W-1:0]   r_tpl_mem [2**TPL_AW];

    // source image: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_src_we) begin
            r_src_mem[i_src_waddr] <= i_src_wdata;
        end
        o_src_rdata <= r_src_mem[i_src_raddr];
    end

    // template: one write, plain and mirrored registered reads
    always_ff @(posedge i_clk) begin
        if (i_tpl_we) begin
            r_tpl_mem[i_tpl_waddr] <= i_tpl_wdata;
        end
        o_tpl_rdata_a <= r_tpl_mem[i_tpl_raddr_a];
        o_tpl_rdata_b <= r_tpl_mem[i_tpl_raddr_b];
    end

endmodule

`default_nettype wire

[src/mst_scan.sv]
// placement and pixel walk that issues one store read per cycle
`default_nettype none

module mst_scan #(
    parameter int MAX_TEMPLATE_WIDTH  = 64,
    parameter int MAX_TEMPLATE_HEIGHT = 64,
    parameter int MAX_SOURCE_WIDTH    = 256,
    parameter int MAX_SOURCE_HEIGHT   = 256,
    parameter int TXW                 = 6,
    parameter int TYW                 = 6,
    parameter int PXW                 = 8,
    parameter int PYW                 = 8,
    parameter int SRC_AW              = 16,
    parameter int TPL_AW              = 12
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire  [TXW-1:0]      i_tx_last,
    input  wire  [TYW-1:0]      i_ty_last,
    input  wire  [PXW-1:0]      i_px_last,
    input  wire  [PYW-1:0]      i_py_last,
    output mst_pkg::t_tag       o_tag,
    output logic [SRC_AW-1:0]   o_src_addr,
    output logic [TPL_AW-1:0]   o_tpl_addr_a,
    output logic [TPL_AW-1:0]   o_tpl_addr_b
);

    logic           r_run;
    logic [TXW-1:0] r_tx;
    logic [TYW-1:0] r_ty;
    logic [PXW-1:0] r_px;
    logic [PYW-1:0] r_py;
    logic           end_tx, end_ty, end_px, end_py;
    logic [SRC_AW-1:0] src_row;
    logic [SRC_AW-1:0] src_col;
    logic [TPL_AW-1:0] tpl_row;

    assign end_tx = (r_tx == i_tx_last);
    assign end_ty = (r_ty == i_ty_last);
    assign end_px = (r_px == i_px_last);
    assign end_py = (r_py == i_py_last);

    // counters: template column, template row, placement column, placement row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_tx  <= '0;
            r_ty  <= '0;
            r_px  <= '0;
            r_py  <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_tx  <= '0;
            r_ty  <= '0;
            r_px  <= '0;
            r_py  <= '0;
        end else if (r_run) begin
            if (!end_tx) begin
                r_tx <= r_tx + 1'b1;
            end else begin
                r_tx <= '0;
                if (!end_ty) begin
                    r_ty <= r_ty + 1'b1;
                end else begin
                    r_ty <= '0;
                    if (!end_px) begin
                        r_px <= r_px + 1'b1;
                    end else begin
                        r_px <= '0;
                        if (!end_py) begin
                            r_py <= r_py + 1'b1;
                        end else begin
                            r_run <= 1'b0;
                        end
                    end
                end
            end
        end
    end

    // tag marks the first and last pixel of each placement
    assign o_tag.valid = r_run;
    assign o_tag.first = (r_tx == '0) && (r_ty == '0);
    assign o_tag.last  = end_tx && end_ty;

    // store addresses, row major
    assign src_row = SRC_AW'(r_py) + SRC_AW'(r_ty);
    assign src_col = SRC_AW'(r_px) + SRC_AW'(r_tx);
    assign o_src_addr = src_row * SRC_AW'(MAX_SOURCE_WIDTH) + src_col;

    assign tpl_row = TPL_AW'(r_ty) * TPL_AW'(MAX_TEMPLATE_WIDTH);
    assign o_tpl_addr_a = tpl_row + TPL_AW'(r_tx);
    assign o_tpl_addr_b = tpl_row + TPL_AW'(i_tx_last - r_tx);

endmodule

`default_nettype wire

[src/mst_sad_unit.sv]
// masked rgb absolute difference and per-placement accumulation
`default_nettype none

module mst_sad_unit #(
    parameter int SUM_W = 22
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  mst_pkg::t_tag                i_tag,
    input  wire  [mst_pkg::PIXEL_W-1:0]  i_src,
    input  wire  [mst_pkg::TPL_W-1:0]    i_tpl_a,
    input  wire  [mst_pkg::TPL_W-1:0]    i_tpl_b,
    output logic                         o_sum_valid,
    output logic [SUM_W-1:0]             o_plain,
    output logic [SUM_W-1:0]             o_mirror
);

    mst_pkg::t_tag r_tag1;
    mst_pkg::t_tag r_tag2;
    logic [9:0]       r_sad_p;
    logic [9:0]       r_sad_m;
    logic [SUM_W-1:0] r_acc_p;
    logic [SUM_W-1:0] r_acc_m;
    logic             r_sum_valid;
    logic [9:0]       n_sad_p;
    logic [9:0]       n_sad_m;

    function automatic logic [9:0] rgb_sad(input logic [23:0] s, input logic [23:0] t);
        logic [7:0] d0, d1, d2;
        d0 = (s[7:0]   > t[7:0])   ? s[7:0]   - t[7:0]   : t[7:0]   - s[7:0];
        d1 = (s[15:8]  > t[15:8])  ? s[15:8]  - t[15:8]  : t[15:8]  - s[15:8];
        d2 = (s[23:16] > t[23:16]) ? s[23:16] - t[23:16] : t[23:16] - s[23:16];
        return 10'(d0) + 10'(d1) + 10'(d2);
    endfunction

    // tag follows the registered store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    // per-pixel differences, zeroed where the keep bit is clear
    always_comb begin
        n_sad_p = i_tpl_a[24] ? rgb_sad(i_src, i_tpl_a[23:0]) : 10'd0;
        n_sad_m = i_tpl_b[24] ? rgb_sad(i_src, i_tpl_b[23:0]) : 10'd0;
    end

    always_ff @(posedge i_clk) begin
        r_sad_p <= n_sad_p;
        r_sad_m <= n_sad_m;
    end

    // accumulate, restarting on the first pixel of a placement
    always_ff @(posedge i_clk) begin
        if (r_tag2.valid) begin
            r_acc_p <= (r_tag2.first ? '0 : r_acc_p) + SUM_W'(r_sad_p);
            r_acc_m <= (r_tag2.first ? '0 : r_acc_m) + SUM_W'(r_sad_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else begin
            r_sum_valid <= r_tag2.valid && r_tag2.last;
        end
    end

    assign o_sum_valid = r_sum_valid;
    assign o_plain     = r_acc_p;
    assign o_mirror    = r_acc_m;

endmodule

`default_nettype wire

[src/mst_divider.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none

module mst_divider #(
    parameter int DVD_W = 22,
    parameter int DVS_W = 13
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire  [DVD_W-1:0]   i_dividend,
    input  wire  [DVS_W-1:0]   i_divisor,
    output logic               o_done,
    output logic [DVD_W-1:0]   o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DVD_W-1:0]   r_quo;
    logic [DVS_W-1:0]   r_rem;
    logic [DVS_W-1:0]   r_div;
    logic [DVS_W:0]     rem_sh;
    logic               q_bit;
    logic [DVS_W:0]     rem_sub;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        rem_sh  = {r_rem, r_quo[DVD_W-1]};
        q_bit   = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

[src/masked_sad_template_match_top.sv]
// top level: config registers, search sequencer, best placement tracking
// a load is written to its store as it is accepted; a search reads one pixel pair per cycle
// from the stores for each placement, then runs a bit-serial divider for the mean difference
// a search with no placement gives its result without scanning; busy is high while a search runs
// synchronous active-low reset restores the config defaults and idles the sequencer;
// the pixel stores are not cleared; results are a one-cycle strobe and cannot be stalled
`default_nettype none

module masked_sad_template_match_top #(
    parameter int MAX_TEMPLATE_WIDTH  = 64,
    parameter int MAX_TEMPLATE_HEIGHT = 64,
    parameter int MAX_SOURCE_WIDTH    = 256,
    parameter int MAX_SOURCE_HEIGHT   = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // command side
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_action,
    input  wire  [7:0]  i_column,
    input  wire  [7:0]  i_row,
    input  wire  [7:0]  i_red,
    input  wire  [7:0]  i_green,
    input  wire  [7:0]  i_blue,
    input  wire         i_template_keep,
    // result side
    output logic        o_result_valid,
    output logic        o_match_found,
    output logic [7:0]  o_best_x,
    output logic [7:0]  o_best_y,
    output logic [9:0]  o_best_difference,
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TXW    = (MAX_TEMPLATE_WIDTH  > 1) ? $clog2(MAX_TEMPLATE_WIDTH)  : 1;
    localparam int TYW    = (MAX_TEMPLATE_HEIGHT > 1) ? $clog2(MAX_TEMPLATE_HEIGHT) : 1;
    localparam int PXW    = $clog2(MAX_SOURCE_WIDTH);
    localparam int PYW    = $clog2(MAX_SOURCE_HEIGHT);
    localparam int TAREA  = MAX_TEMPLATE_WIDTH * MAX_TEMPLATE_HEIGHT;
    localparam int TPL_AW = (TAREA > 1) ? $clog2(TAREA) : 1;
    localparam int SRC_AW = $clog2(MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT);
    localparam int AW     = $clog2(TAREA + 1);
    localparam int SUM_W  = $clog2(TAREA * 765 + 1);

    // configuration registers, raw as written
    logic [6:0] r_cfg_tw;
    logic [6:0] r_cfg_th;
    logic [8:0] r_cfg_sw;
    logic [8:0] r_cfg_sh;

    mst_pkg::t_state r_state, n_state;

    // search setup latched at the start of a search
    logic [TXW-1:0] r_tx_last;
    logic [TYW-1:0] r_ty_last;
    logic [PXW-1:0] r_px_last;
    logic [PYW-1:0] r_py_last;
    logic [AW-1:0]  r_area;

    // best placement tracking
    logic [PXW-1:0]   r_cpx;
    logic [PYW-1:0]   r_cpy;
    logic             r_have;
    logic [SUM_W-1:0] r_best;
    logic [PXW-1:0]   r_bx;
    logic [PYW-1:0]   r_by;

    // result registers
    logic              r_out_valid;
    logic              r_found;
    logic [mst_pkg::DIFF_W-1:0] r_diff;

    logic accept;
    logic search_go;
    logic fits;
    logic [TXW-1:0] c_tx_last;
    logic [TYW-1:0] c_ty_last;
    logic [PXW-1:0] c_px_last;
    logic [PYW-1:0] c_py_last;
    logic [AW-1:0]  c_area;

    logic                        src_we;
    logic [SRC_AW-1:0]           src_waddr;
    logic                        tpl_we;
    logic [TPL_AW-1:0]           tpl_waddr;
    logic [mst_pkg::PIXEL_W-1:0] src_rdata;
    logic [mst_pkg::TPL_W-1:0]   tpl_rdata_a;
    logic [mst_pkg::TPL_W-1:0]   tpl_rdata_b;

    mst_pkg::t_tag     scan_tag;
    logic [SRC_AW-1:0] scan_src_addr;
    logic [TPL_AW-1:0] scan_tpl_addr_a;
    logic [TPL_AW-1:0] scan_tpl_addr_b;

    logic             sum_valid;
    logic [SUM_W-1:0] sum_plain;
    logic [SUM_W-1:0] sum_mirror;
    logic             win_p;
    logic             win_m;
    logic [SUM_W-1:0] low_p;
    logic             last_placement;

    logic             div_start;
    logic             div_done;
    logic [SUM_W-1:0] div_quotient;

    assign accept = start && !busy;
    assign busy   = (r_state != mst_pkg::ST_IDLE);
    assign pready = 1'b1;

    // configuration write transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_tw <= mst_pkg::TEMPLATE_WIDTH_RESET;
            r_cfg_th <= mst_pkg::TEMPLATE_HEIGHT_RESET;
            r_cfg_sw <= mst_pkg::SOURCE_WIDTH_RESET;
            r_cfg_sh <= mst_pkg::SOURCE_HEIGHT_RESET;
        end else if (psel && penable && pwrite) begin
            case (mst_pkg::t_reg_index'(paddr[3:2]))
                mst_pkg::REG_TEMPLATE_WIDTH:  r_cfg_tw <= pwdata[6:0];
                mst_pkg::REG_TEMPLATE_HEIGHT: r_cfg_th <= pwdata[6:0];
                mst_pkg::REG_SOURCE_WIDTH:    r_cfg_sw <= pwdata[8:0];
                mst_pkg::REG_SOURCE_HEIGHT:   r_cfg_sh <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // configuration read
    always_comb begin
        case (mst_pkg::t_reg_index'(paddr[3:2]))
            mst_pkg::REG_TEMPLATE_WIDTH:  prdata = 32'(r_cfg_tw);
            mst_pkg::REG_TEMPLATE_HEIGHT: prdata = 32'(r_cfg_th);
            mst_pkg::REG_SOURCE_WIDTH:    prdata = 32'(r_cfg_sw);
            mst_pkg::REG_SOURCE_HEIGHT:   prdata = 32'(r_cfg_sh);
            default:                      prdata = '0;
        endcase
    end

    // clamp the dimensions and derive the scan limits
    always_comb begin
        int tw, th, sw, sh;
        tw = (r_cfg_tw == '0) ? 1 : int'(r_cfg_tw);
        th = (r_cfg_th == '0) ? 1 : int'(r_cfg_th);
        sw = (r_cfg_sw == '0) ? 1 : int'(r_cfg_sw);
        sh = (r_cfg_sh == '0) ? 1 : int'(r_cfg_sh);
        if (tw > MAX_TEMPLATE_WIDTH)  tw = MAX_TEMPLATE_WIDTH;
        if (th > MAX_TEMPLATE_HEIGHT) th = MAX_TEMPLATE_HEIGHT;
        if (sw > MAX_SOURCE_WIDTH)    sw = MAX_SOURCE_WIDTH;
        if (sh > MAX_SOURCE_HEIGHT)   sh = MAX_SOURCE_HEIGHT;
        fits      = (tw <= sw) && (th <= sh);
        c_tx_last = TXW'(tw - 1);
        c_ty_last = TYW'(th - 1);
        c_px_last = PXW'(sw - tw);
        c_py_last = PYW'(sh - th);
        c_area    = AW'(tw * th);
    end

    assign search_go = accept && (mst_pkg::t_action'(i_action) == mst_pkg::ACT_SEARCH);

    // pixel load transfers, out-of-range coordinates dropped
    always_comb begin
        src_we    = 1'b0;
        tpl_we    = 1'b0;
        src_waddr = SRC_AW'(int'(i_row) * MAX_SOURCE_WIDTH + int'(i_column));
        tpl_waddr = TPL_AW'(int'(i_row) * MAX_TEMPLATE_WIDTH + int'(i_column));
        if (accept) begin
            case (mst_pkg::t_action'(i_action))
                mst_pkg::ACT_LOAD_TEMPLATE:
                    tpl_we = (int'(i_column) < MAX_TEMPLATE_WIDTH) &&
                             (int'(i_row) < MAX_TEMPLATE_HEIGHT);
                mst_pkg::ACT_LOAD_SOURCE:
                    src_we = (int'(i_column) < MAX_SOURCE_WIDTH) &&
                             (int'(i_row) < MAX_SOURCE_HEIGHT);
                default: ;
            endcase
        end
    end

    mst_stores #(
        .SRC_AW (SRC_AW),
        .TPL_AW (TPL_AW)
    ) u_stores (
        .i_clk         (i_clk),
        .i_src_we      (src_we),
        .i_src_waddr   (src_waddr),
        .i_src_wdata   ({i_blue, i_green, i_red}),
        .i_src_raddr   (scan_src_addr),
        .o_src_rdata   (src_rdata),
        .i_tpl_we      (tpl_we),
        .i_tpl_waddr   (tpl_waddr),
        .i_tpl_wdata   ({i_template_keep, i_blue, i_green, i_red}),
        .i_tpl_raddr_a (scan_tpl_addr_a),
        .i_tpl_raddr_b (scan_tpl_addr_b),
        .o_tpl_rdata_a (tpl_rdata_a),
        .o_tpl_rdata_b (tpl_rdata_b)
    );

    mst_scan #(
        .MAX_TEMPLATE_WIDTH  (MAX_TEMPLATE_WIDTH),
        .MAX_TEMPLATE_HEIGHT (MAX_TEMPLATE_HEIGHT),
        .MAX_SOURCE_WIDTH    (MAX_SOURCE_WIDTH),
        .MAX_SOURCE_HEIGHT   (MAX_SOURCE_HEIGHT),
        .TXW                 (TXW),
        .TYW                 (TYW),
        .PXW                 (PXW),
        .PYW                 (PYW),
        .SRC_AW              (SRC_AW),
        .TPL_AW              (TPL_AW)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (search_go && fits),
        .i_tx_last    (r_tx_last),
        .i_ty_last    (r_ty_last),
        .i_px_last    (r_px_last),
        .i_py_last    (r_py_last),
        .o_tag        (scan_tag),
        .o_src_addr   (scan_src_addr),
        .o_tpl_addr_a (scan_tpl_addr_a),
        .o_tpl_addr_b (scan_tpl_addr_b)
    );

    mst_sad_unit #(
        .SUM_W (SUM_W)
    ) u_sad (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (scan_tag),
        .i_src       (src_rdata),
        .i_tpl_a     (tpl_rdata_a),
        .i_tpl_b     (tpl_rdata_b),
        .o_sum_valid (sum_valid),
        .o_plain     (sum_plain),
        .o_mirror    (sum_mirror)
    );

    // plain sum tested before mirrored, strict improvement only
    always_comb begin
        win_p          = !r_have || (sum_plain < r_best);
        low_p          = win_p ? sum_plain : r_best;
        win_m          = (sum_mirror < low_p);
        last_placement = (r_cpx == r_px_last) && (r_cpy == r_py_last);
    end

    // setup latch and best placement tracking
    always_ff @(posedge i_clk) begin
        if (search_go) begin
            r_tx_last <= c_tx_last;
            r_ty_last <= c_ty_last;
            r_px_last <= c_px_last;
            r_py_last <= c_py_last;
            r_area    <= c_area;
            r_cpx     <= '0;
            r_cpy     <= '0;
            r_best    <= '0;
            r_bx      <= '0;
            r_by      <= '0;
        end else if (sum_valid) begin
            if (r_cpx == r_px_last) begin
                r_cpx <= '0;
                r_cpy <= r_cpy + 1'b1;
            end else begin
                r_cpx <= r_cpx + 1'b1;
            end
            if (win_m) begin
                r_best <= sum_mirror;
                r_bx   <= r_cpx;
                r_by   <= r_cpy;
            end else if (win_p) begin
                r_best <= sum_plain;
                r_bx   <= r_cpx;
                r_by   <= r_cpy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (search_go) begin
            r_have <= 1'b0;
        end else if (sum_valid) begin
            r_have <= 1'b1;
        end
    end

    assign div_start = (r_state == mst_pkg::ST_DIV_LOAD);

    mst_divider #(
        .DVD_W (SUM_W),
        .DVS_W (AW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_best),
        .i_divisor  (r_area),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mst_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mst_pkg::ST_IDLE: begin
                if (search_go && fits) begin
                    n_state = mst_pkg::ST_SCAN;
                end
            end
            mst_pkg::ST_SCAN: begin
                if (sum_valid && last_placement) begin
                    n_state = mst_pkg::ST_DIV_LOAD;
                end
            end
            mst_pkg::ST_DIV_LOAD: begin
                n_state = mst_pkg::ST_DIV_WAIT;
            end
            mst_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = mst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mst_pkg::ST_IDLE;
            end
        endcase
    end

    // result transfer strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (search_go && !fits) ||
                           ((r_state == mst_pkg::ST_DIV_WAIT) && div_done);
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        if (search_go && !fits) begin
            r_found <= 1'b0;
            r_diff  <= '0;
        end else if ((r_state == mst_pkg::ST_DIV_WAIT) && div_done) begin
            r_found <= 1'b1;
            r_diff  <= mst_pkg::DIFF_W'(div_quotient);
        end
    end

    assign o_result_valid    = r_out_valid;
    assign o_match_found     = r_found;
    assign o_best_x          = 8'(r_bx);
    assign o_best_y          = 8'(r_by);
    assign o_best_difference = r_diff;

endmodule

`default_nettype wire

[sim/tb.sv]
// self-checking testbench for the masked sad template matcher top level
`default_nettype none

module tb;
    import mst_pkg::*;

    localparam int unsigned TPL_MAX        = 64;
    localparam int unsigned SRC_MAX        = 256;
    localparam int unsigned START_LOWEST   = 32'd1337433434;
    localparam int unsigned ITEM_TARGET    = 1250;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned DRAIN_CYCLES   = 64;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam logic [1:0]  ACT_UNUSED     = 2'd3;

    // one pixel command as driven on the command side
    typedef struct packed {
        logic [1:0] act;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       keep;
    } pixel_cmd_t;

    // one search answer
    typedef struct packed {
        logic       found;
        logic [7:0] x;
        logic [7:0] y;
        logic [9:0] diff;
    } match_t;

    // one line of the directed stimulus: a register write or a command
    typedef struct {
        bit         is_cfg;
        t_reg_index idx;
        logic [8:0] value;
        pixel_cmd_t cmd;
        bit         typed;
        match_t     res;
    } stim_step_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  i_action = '0;
    logic [7:0]  i_column = '0;
    logic [7:0]  i_row = '0;
    logic [7:0]  i_red = '0;
    logic [7:0]  i_green = '0;
    logic [7:0]  i_blue = '0;
    logic        i_template_keep = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        busy;
    logic        o_result_valid;
    logic        o_match_found;
    logic [7:0]  o_best_x;
    logic [7:0]  o_best_y;
    logic [9:0]  o_best_difference;
    logic [31:0] prdata;
    logic        pready;

    // shadow copy of the pixel stores and of what has been written since reset
    logic [23:0] src_pixels [0:SRC_MAX*SRC_MAX-1];
    logic [24:0] tpl_pixels [0:TPL_MAX*TPL_MAX-1];
    bit          src_loaded [0:SRC_MAX*SRC_MAX-1];
    bit          tpl_loaded [0:TPL_MAX*TPL_MAX-1];

    // shadow copy of the dimension registers
    logic [6:0] tw_reg = TEMPLATE_WIDTH_RESET;
    logic [6:0] th_reg = TEMPLATE_HEIGHT_RESET;
    logic [8:0] sw_reg = SOURCE_WIDTH_RESET;
    logic [8:0] sh_reg = SOURCE_HEIGHT_RESET;

    match_t      pending_matches [$];
    stim_step_t  directed_steps [$];
    int unsigned mismatch_count = 0;
    int unsigned accepted_items = 0;
    int unsigned gap_limit = 11;
    bit          narrow_vals = 1'b0;

    masked_sad_template_match_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_action          (i_action),
        .i_column          (i_column),
        .i_row             (i_row),
        .i_red             (i_red),
        .i_green           (i_green),
        .i_blue            (i_blue),
        .i_template_keep   (i_template_keep),
        .o_result_valid    (o_result_valid),
        .o_match_found     (o_match_found),
        .o_best_x          (o_best_x),
        .o_best_y          (o_best_y),
        .o_best_difference (o_best_difference),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #5 i_clk = ~i_clk;

    // failure bookkeeping, only the first few are printed
    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endfunction

    // 0 reads as 1, anything above the maximum as the maximum
    function automatic int unsigned eff_dim(input int unsigned v, input int unsigned maxv);
        if (v == 0) begin
            return 1;
        end
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic int unsigned pixel_sad(input logic [23:0] a, input logic [23:0] b);
        int unsigned sum;
        int unsigned ca;
        int unsigned cb;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            ca = a[8*k +: 8];
            cb = b[8*k +: 8];
            sum += (ca > cb) ? ca - cb : cb - ca;
        end
        return sum;
    endfunction

    // full placement scan, plain sum before mirrored sum, strict improvement only
    function automatic match_t predict_match();
        int unsigned tw, th, sw, sh, area, lowest, plain, mirror;
        logic [23:0] s;
        logic [24:0] t;
        logic [24:0] m;
        match_t r;
        tw = eff_dim(tw_reg, TPL_MAX);
        th = eff_dim(th_reg, TPL_MAX);
        sw = eff_dim(sw_reg, SRC_MAX);
        sh = eff_dim(sh_reg, SRC_MAX);
        area = tw * th;
        lowest = START_LOWEST;
        r = '0;
        if (tw <= sw && th <= sh) begin
            for (int unsigned py = 0; py <= sh - th; py++) begin
                for (int unsigned px = 0; px <= sw - tw; px++) begin
                    plain = 0;
                    mirror = 0;
                    for (int unsigned ty = 0; ty < th; ty++) begin
                        for (int unsigned tx = 0; tx < tw; tx++) begin
                            s = src_pixels[(py + ty) * SRC_MAX + px + tx];
                            t = tpl_pixels[ty * TPL_MAX + tx];
                            m = tpl_pixels[ty * TPL_MAX + tw - 1 - tx];
                            if (t[24]) begin
                                plain += pixel_sad(s, t[23:0]);
                            end
                            if (m[24]) begin
                                mirror += pixel_sad(s, m[23:0]);
                            end
                        end
                    end
                    r.found = 1'b1;
                    if (plain < lowest) begin
                        lowest = plain;
                        r.x = 8'(px);
                        r.y = 8'(py);
                        r.diff = 10'(plain / area);
                    end
                    if (mirror < lowest) begin
                        lowest = mirror;
                        r.x = 8'(px);
                        r.y = 8'(py);
                        r.diff = 10'(mirror / area);
                    end
                end
            end
        end
        return r;
    endfunction

    // update the shadow state for an accepted command, queue the answer of a search
    function automatic void apply_cmd(input pixel_cmd_t c, input bit typed, input match_t res);
        if (c.act == ACT_LOAD_TEMPLATE) begin
            if (c.col < TPL_MAX && c.row < TPL_MAX) begin
                tpl_pixels[c.row * TPL_MAX + c.col] = {c.keep, c.blue, c.green, c.red};
                tpl_loaded[c.row * TPL_MAX + c.col] = 1'b1;
                accepted_items++;
            end
        end else if (c.act == ACT_LOAD_SOURCE) begin
            src_pixels[c.row * SRC_MAX + c.col] = {c.blue, c.green, c.red};
            src_loaded[c.row * SRC_MAX + c.col] = 1'b1;
            accepted_items++;
        end else if (c.act == ACT_SEARCH) begin
            pending_matches.push_back(typed ? res : predict_match());
            accepted_items++;
        end
    endfunction

    function automatic logic [31:0] cfg_value(input t_reg_index idx);
        case (idx)
            REG_TEMPLATE_WIDTH:  return {25'd0, tw_reg};
            REG_TEMPLATE_HEIGHT: return {25'd0, th_reg};
            REG_SOURCE_WIDTH:    return {23'd0, sw_reg};
            default:             return {23'd0, sh_reg};
        endcase
    endfunction

    // channel values, sometimes pinned to the ends or squeezed to provoke ties
    function automatic logic [7:0] rand_chan();
        if (narrow_vals) begin
            return 8'($urandom_range(0, 3));
        end
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic pixel_cmd_t rand_cmd(input logic [1:0] act, input logic [7:0] col,
                                            input logic [7:0] row);
        pixel_cmd_t c;
        c.act = act;
        c.col = col;
        c.row = row;
        c.red = rand_chan();
        c.green = rand_chan();
        c.blue = rand_chan();
        c.keep = ($urandom_range(0, 3) != 0);
        return c;
    endfunction

    // raw register value for a wanted size, using the aliases 0 and above-maximum
    function automatic logic [8:0] raw_dim(input int unsigned eff, input int unsigned maxv,
                                           input int unsigned top);
        if (eff == 1 && $urandom_range(0, 2) == 0) begin
            return 9'd0;
        end
        if (eff == maxv) begin
            case ($urandom_range(0, 2))
                0:       return 9'(top);
                1:       return 9'($urandom_range(maxv + 1, top));
                default: return 9'(maxv);
            endcase
        end
        return 9'(eff);
    endfunction

    // directed table builders
    function automatic void cfg_row(input t_reg_index idx, input logic [8:0] value);
        stim_step_t s;
        s.is_cfg = 1'b1;
        s.idx = idx;
        s.value = value;
        s.cmd = '0;
        s.typed = 1'b0;
        s.res = '0;
        directed_steps.push_back(s);
    endfunction

    function automatic void cmd_row(input logic [1:0] act, input logic [7:0] col,
                                    input logic [7:0] row, input logic [7:0] red,
                                    input logic [7:0] green, input logic [7:0] blue,
                                    input logic keep);
        stim_step_t s;
        s.is_cfg = 1'b0;
        s.idx = REG_TEMPLATE_WIDTH;
        s.value = '0;
        s.cmd = {act, col, row, red, green, blue, keep};
        s.typed = 1'b0;
        s.res = '0;
        directed_steps.push_back(s);
    endfunction

    function automatic void search_row(input bit typed, input logic found,
                                       input logic [7:0] x, input logic [7:0] y,
                                       input logic [9:0] diff);
        stim_step_t s;
        s.is_cfg = 1'b0;
        s.idx = REG_TEMPLATE_WIDTH;
        s.value = '0;
        s.cmd = rand_cmd(ACT_SEARCH, 8'($urandom), 8'($urandom));
        s.typed = typed;
        s.res = {found, x, y, diff};
        directed_steps.push_back(s);
    endfunction

    // one apb transfer, returns at the access edge with psel still high
    task automatic apb_xfer(input logic wr, input t_reg_index idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
    endtask

    // register write while idle, then read it back
    task automatic cfg_write(input t_reg_index idx, input logic [8:0] value);
        logic [31:0] rd;
        start <= 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        apb_xfer(1'b1, idx, {23'd0, value}, rd);
        case (idx)
            REG_TEMPLATE_WIDTH:  tw_reg = value[6:0];
            REG_TEMPLATE_HEIGHT: th_reg = value[6:0];
            REG_SOURCE_WIDTH:    sw_reg = value;
            default:             sh_reg = value;
        endcase
        apb_xfer(1'b0, idx, 32'd0, rd);
        if (rd !== cfg_value(idx)) begin
            note_mismatch($sformatf("register %s readback: expected %0d, got %0d",
                                    idx.name(), cfg_value(idx), rd));
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // command transfer after a random gap; start stays high when no gap follows
    task automatic send_cmd(input pixel_cmd_t c, input bit typed, input match_t res);
        int unsigned gap;
        gap = $urandom_range(0, gap_limit);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_action <= c.act;
        i_column <= c.col;
        i_row <= c.row;
        i_red <= c.red;
        i_green <= c.green;
        i_blue <= c.blue;
        i_template_keep <= c.keep;
        do @(posedge i_clk); while (busy !== 1'b0);
        apply_cmd(c, typed, res);
    endtask

    // one random phase: sizes, loading of anything not yet written, mixed traffic
    task automatic run_phase(input int unsigned phase_no);
        int unsigned tw, th, sw, sh, n_mix, pick;
        if (phase_no % 8 == 7) begin
            case ($urandom_range(0, 2))
                0: begin
                    tw = TPL_MAX; th = 1; sw = SRC_MAX; sh = 1;
                end
                1: begin
                    tw = 1; th = TPL_MAX; sw = 1; sh = SRC_MAX;
                end
                default: begin
                    tw = TPL_MAX; th = TPL_MAX;
                    sw = $urandom_range(1, TPL_MAX - 1); sh = $urandom_range(1, TPL_MAX);
                end
            endcase
            n_mix = $urandom_range(2, 6);
        end else begin
            tw = $urandom_range(1, 4);
            th = $urandom_range(1, 4);
            sw = $urandom_range(1, 12);
            sh = $urandom_range(1, 8);
            n_mix = $urandom_range(3, 24);
        end
        gap_limit = ($urandom_range(0, 3) == 0) ? 0 : 11;
        narrow_vals = ($urandom_range(0, 3) == 0);
        cfg_write(REG_TEMPLATE_WIDTH, raw_dim(tw, TPL_MAX, 127));
        cfg_write(REG_TEMPLATE_HEIGHT, raw_dim(th, TPL_MAX, 127));
        cfg_write(REG_SOURCE_WIDTH, raw_dim(sw, SRC_MAX, 511));
        cfg_write(REG_SOURCE_HEIGHT, raw_dim(sh, SRC_MAX, 511));

        // every pixel a search will read must have been loaded
        if (tw <= sw && th <= sh) begin
            for (int unsigned y = 0; y < th; y++) begin
                for (int unsigned x = 0; x < tw; x++) begin
                    if (!tpl_loaded[y * TPL_MAX + x]) begin
                        send_cmd(rand_cmd(ACT_LOAD_TEMPLATE, 8'(x), 8'(y)), 1'b0, '0);
                    end
                end
            end
            for (int unsigned y = 0; y < sh; y++) begin
                for (int unsigned x = 0; x < sw; x++) begin
                    if (!src_loaded[y * SRC_MAX + x]) begin
                        send_cmd(rand_cmd(ACT_LOAD_SOURCE, 8'(x), 8'(y)), 1'b0, '0);
                    end
                end
            end
        end

        // reloads inside the window, loads anywhere, unused actions and searches
        for (int unsigned k = 0; k < n_mix; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                send_cmd(rand_cmd(ACT_LOAD_TEMPLATE, 8'($urandom_range(0, tw - 1)),
                                  8'($urandom_range(0, th - 1))), 1'b0, '0);
            end else if (pick < 65) begin
                send_cmd(rand_cmd(ACT_LOAD_SOURCE, 8'($urandom_range(0, sw - 1)),
                                  8'($urandom_range(0, sh - 1))), 1'b0, '0);
            end else if (pick < 75) begin
                send_cmd(rand_cmd(2'($urandom_range(0, 1)), 8'($urandom), 8'($urandom)),
                         1'b0, '0);
            end else if (pick < 82) begin
                send_cmd(rand_cmd(ACT_UNUSED, 8'($urandom), 8'($urandom)), 1'b0, '0);
            end else begin
                send_cmd(rand_cmd(ACT_SEARCH, 8'($urandom), 8'($urandom)), 1'b0, '0);
            end
        end
        send_cmd(rand_cmd(ACT_SEARCH, 8'($urandom), 8'($urandom)), 1'b0, '0);
    endtask

    // result side: each strobe is matched against the oldest pending answer
    always @(posedge i_clk) begin : result_check
        match_t got;
        match_t want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            got.found = o_match_found;
            got.x = o_best_x;
            got.y = o_best_y;
            got.diff = o_best_difference;
            if (pending_matches.size() == 0) begin
                note_mismatch($sformatf("result with no search pending: found=%0d x=%0d y=%0d diff=%0d",
                                        got.found, got.x, got.y, got.diff));
            end else begin
                want = pending_matches.pop_front();
                if (got.found !== want.found || got.x !== want.x ||
                    got.y !== want.y || got.diff !== want.diff) begin
                    note_mismatch($sformatf({"result mismatch: expected found=%0d x=%0d y=%0d",
                                             " diff=%0d, got found=%0d x=%0d y=%0d diff=%0d"},
                                            want.found, want.x, want.y, want.diff,
                                            got.found, got.x, got.y, got.diff));
                end
            end
        end
    end

    // run limit
    initial begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

    // main sequence
    initial begin : stimulus
        logic [31:0] rd;
        int unsigned phase_no;

        // smallest sizes, largest difference
        cfg_row(REG_TEMPLATE_WIDTH, 9'd1);
        cfg_row(REG_TEMPLATE_HEIGHT, 9'd1);
        cfg_row(REG_SOURCE_WIDTH, 9'd1);
        cfg_row(REG_SOURCE_HEIGHT, 9'd1);
        cmd_row(ACT_LOAD_TEMPLATE, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1);
        cmd_row(ACT_LOAD_SOURCE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        search_row(1'b1, 1'b1, 8'd0, 8'd0, 10'd765);
        // nothing kept gives zero at the first placement
        cmd_row(ACT_LOAD_TEMPLATE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        search_row(1'b1, 1'b1, 8'd0, 8'd0, 10'd0);
        // template loads beyond the store are dropped, unused action does nothing
        cmd_row(ACT_LOAD_TEMPLATE, 8'd64, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1);
        cmd_row(ACT_LOAD_TEMPLATE, 8'd0, 8'd64, 8'd255, 8'd255, 8'd255, 1'b1);
        cmd_row(ACT_LOAD_TEMPLATE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        cmd_row(ACT_LOAD_SOURCE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        cmd_row(ACT_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        search_row(1'b1, 1'b1, 8'd0, 8'd0, 10'd0);
        // width 0 taken as 1, height above maximum: template taller than source
        cfg_row(REG_TEMPLATE_WIDTH, 9'd0);
        cfg_row(REG_TEMPLATE_HEIGHT, 9'd127);
        search_row(1'b1, 1'b0, 8'd0, 8'd0, 10'd0);
        cfg_row(REG_TEMPLATE_HEIGHT, 9'd0);
        cfg_row(REG_SOURCE_WIDTH, 9'd0);
        cfg_row(REG_SOURCE_HEIGHT, 9'd0);
        cmd_row(ACT_LOAD_TEMPLATE, 8'd0, 8'd0, 8'd10, 8'd20, 8'd30, 1'b1);
        cmd_row(ACT_LOAD_SOURCE, 8'd0, 8'd0, 8'd13, 8'd17, 8'd40, 1'b0);
        search_row(1'b1, 1'b1, 8'd0, 8'd0, 10'd16);
        // mirrored template and mask win where the plain one does not
        cfg_row(REG_TEMPLATE_WIDTH, 9'd2);
        cfg_row(REG_SOURCE_WIDTH, 9'd3);
        cmd_row(ACT_LOAD_TEMPLATE, 8'd0, 8'd0, 8'd100, 8'd100, 8'd100, 1'b1);
        cmd_row(ACT_LOAD_TEMPLATE, 8'd1, 8'd0, 8'd7, 8'd8, 8'd9, 1'b0);
        cmd_row(ACT_LOAD_SOURCE, 8'd1, 8'd0, 8'd100, 8'd100, 8'd100, 1'b0);
        cmd_row(ACT_LOAD_SOURCE, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        search_row(1'b1, 1'b1, 8'd0, 8'd0, 10'd0);
        // equal sums later on keep the earlier placement
        cmd_row(ACT_LOAD_SOURCE, 8'd1, 8'd0, 8'd50, 8'd50, 8'd50, 1'b0);
        search_row(1'b0, 1'b0, 8'd0, 8'd0, 10'd0);
        cmd_row(ACT_LOAD_SOURCE, 8'd2, 8'd0, 8'd50, 8'd50, 8'd50, 1'b0);
        search_row(1'b0, 1'b0, 8'd0, 8'd0, 10'd0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values of the registers
        for (int k = 0; k < 4; k++) begin
            apb_xfer(1'b0, t_reg_index'(k), 32'd0, rd);
            if (rd !== cfg_value(t_reg_index'(k))) begin
                note_mismatch($sformatf("register %0d after reset: expected %0d, got %0d",
                                        k, cfg_value(t_reg_index'(k)), rd));
            end
        end
        psel <= 1'b0;
        penable <= 1'b0;

        // directed table
        foreach (directed_steps[i]) begin
            if (directed_steps[i].is_cfg) begin
                cfg_write(directed_steps[i].idx, directed_steps[i].value);
            end else begin
                send_cmd(directed_steps[i].cmd, directed_steps[i].typed, directed_steps[i].res);
            end
        end

        // random phases
        phase_no = 0;
        while (accepted_items < ITEM_TARGET) begin
            run_phase(phase_no);
            phase_no++;
        end

        // drain
        start <= 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_matches.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
